[rtl/core/swmm_pkg.sv]
// Shared types and constants for the sliding window min/max/mean block.
// No dependencies.
package swmm_pkg;

  localparam int MAX_WINDOW_DEF  = 16;
  localparam int SAMPLE_BITS_DEF = 10;

  // Length register and sample count widths are fixed by the register map.
  localparam int LEN_W  = 5;
  localparam int HELD_W = 5;
  localparam logic [LEN_W-1:0] LEN_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_WORK,
    ST_HOLD
  } swmm_state_e;

  typedef struct packed {
    logic capture;  // take input beat, prefetch the slot being replaced
    logic update;   // write ring, update sum/count, launch scan and divide
    logic load;     // move results into the output register
  } swmm_cmd_t;

  typedef struct packed {
    logic work_done;
  } swmm_sts_t;

endpackage

[rtl/core/swmm_ctrl.sv]
// Controller FSM for the sliding window min/max/mean block.
// Depends on swmm_pkg.
module swmm_ctrl
  import swmm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  swmm_sts_t sts_i,
  output swmm_cmd_t cmd_o
);

  swmm_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        load_ok;

  assign load_ok = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_UPDATE;
      end
      ST_UPDATE: state_d = ST_WORK;
      ST_WORK: begin
        if (sts_i.work_done) state_d = ST_HOLD;
      end
      ST_HOLD: begin
        if (load_ok) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_UPDATE: cmd_o.update = 1'b1;
      ST_WORK:   ;
      ST_HOLD:   cmd_o.load = load_ok;
      default:   ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[rtl/core/swmm_dpath.sv]
// Datapath: sample ring memory, running sum, min/max scan and serial divider.
// Depends on swmm_pkg.
module swmm_dpath
  import swmm_pkg::*;
#(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [LEN_W-1:0]       cfg_len_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  swmm_cmd_t              cmd_i,
  output swmm_sts_t              sts_o,
  output logic [SAMPLE_BITS-1:0] max_o,
  output logic [SAMPLE_BITS-1:0] min_o,
  output logic [SAMPLE_BITS-1:0] mean_o,
  output logic [HELD_W-1:0]      held_o
);

  localparam int IDX_W  = $clog2(MAX_WINDOW);
  localparam int SUM_W  = SAMPLE_BITS + HELD_W;
  localparam int DCNT_W = $clog2(SUM_W + 1);

  logic [SAMPLE_BITS-1:0] ring_mem [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] rd_q;
  logic [IDX_W-1:0]       rd_addr;

  logic [LEN_W-1:0]       len_q;
  logic [HELD_W-1:0]      fill_q, fill_d;
  logic [HELD_W-1:0]      slot_q, slot_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [SAMPLE_BITS-1:0] sample_q;

  logic [HELD_W-1:0]      len_eff, slot_eff;
  logic [HELD_W:0]        slot_nxt;
  logic                   full;

  logic [HELD_W-1:0]      scan_q;
  logic                   scan_run_q, rv_q, first_q;
  logic [SAMPLE_BITS-1:0] max_q, min_q;

  logic [DCNT_W-1:0]      dcnt_q;
  logic [HELD_W-1:0]      rem_q;
  logic [SUM_W-1:0]       quo_q;
  logic [HELD_W:0]        rem_sh, rem_sub;
  logic                   rem_ge;

  logic [SAMPLE_BITS-1:0] max_out_q, min_out_q, mean_out_q;
  logic [HELD_W-1:0]      held_out_q;

  // Zero acts as one, oversize clamps to the ring depth.
  always_comb begin
    if (len_q == '0) begin
      len_eff = HELD_W'(1);
    end else if (32'(len_q) > MAX_WINDOW) begin
      len_eff = HELD_W'(MAX_WINDOW);
    end else begin
      len_eff = HELD_W'(len_q);
    end
  end

  assign slot_eff = (slot_q >= len_eff) ? '0 : slot_q;
  assign slot_nxt = {1'b0, slot_eff} + (HELD_W+1)'(1);
  assign full     = (fill_q >= len_eff);

  always_comb begin
    fill_d = full ? len_eff : fill_q + HELD_W'(1);
    slot_d = (slot_nxt >= {1'b0, len_eff}) ? '0 : HELD_W'(slot_nxt);
    sum_d  = sum_q - (full ? SUM_W'(rd_q) : '0) + SUM_W'(sample_q);
  end

  assign rd_addr = cmd_i.capture ? IDX_W'(slot_eff) : IDX_W'(scan_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) ring_mem[IDX_W'(slot_eff)] <= sample_q;
    rd_q <= ring_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) sample_q <= sample_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= LEN_RESET;
      fill_q <= '0;
      slot_q <= '0;
      sum_q  <= '0;
    end else if (cfg_we_i) begin
      len_q  <= cfg_len_i;
      fill_q <= '0;
      slot_q <= '0;
      sum_q  <= '0;
    end else if (cmd_i.update) begin
      fill_q <= fill_d;
      slot_q <= slot_d;
      sum_q  <= sum_d;
    end
  end

  // Min/max scan over ring entries 0..fill-1, one read per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q     <= '0;
      scan_run_q <= 1'b0;
      rv_q       <= 1'b0;
      first_q    <= 1'b0;
    end else begin
      rv_q <= scan_run_q;
      if (cmd_i.update) begin
        scan_q     <= '0;
        scan_run_q <= 1'b1;
        first_q    <= 1'b1;
      end else if (scan_run_q) begin
        scan_q <= scan_q + HELD_W'(1);
        if (scan_q + HELD_W'(1) == fill_q) scan_run_q <= 1'b0;
      end
      if (rv_q) first_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rv_q) begin
      if (first_q || rd_q > max_q) max_q <= rd_q;
      if (first_q || rd_q < min_q) min_q <= rd_q;
    end
  end

  // Restoring divider, one quotient bit per cycle.
  assign rem_sh  = {rem_q, quo_q[SUM_W-1]};
  assign rem_ge  = (rem_sh >= {1'b0, fill_q});
  assign rem_sub = rem_sh - {1'b0, fill_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.update) begin
      dcnt_q <= DCNT_W'(SUM_W);
    end else if (dcnt_q != '0) begin
      dcnt_q <= dcnt_q - DCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      rem_q <= '0;
      quo_q <= sum_d;
    end else if (dcnt_q != '0) begin
      rem_q <= rem_ge ? HELD_W'(rem_sub) : HELD_W'(rem_sh);
      quo_q <= {quo_q[SUM_W-2:0], rem_ge};
    end
  end

  assign sts_o.work_done = !scan_run_q && !rv_q && (dcnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      max_out_q  <= max_q;
      min_out_q  <= min_q;
      mean_out_q <= quo_q[SAMPLE_BITS-1:0];
      held_out_q <= fill_q;
    end
  end

  assign max_o  = max_out_q;
  assign min_o  = min_out_q;
  assign mean_o = mean_out_q;
  assign held_o = held_out_q;

endmodule

[rtl/core/sliding_window_min_max_mean.sv]
// Top level of the sliding window min/max/mean block.
// Depends on swmm_pkg, swmm_ctrl and swmm_dpath.
//
//  channel  handshake               payload
//  -------  ----------------------  ------------------------------------------
//  input    in_valid_i/in_ready_o   sample_i
//  output   out_valid_o/out_ready_i window_max_o, window_min_o, window_mean_o,
//                                   samples_held_o
//  config   cfg_we_i                window_length_i
//
// The min/max scan reads one ring entry per cycle while the restoring divider
// forms one quotient bit per cycle; both start together. A new input is taken
// while the previous result still sits in the output register. Reset and any
// length write empty the window; ring contents need no clearing.
module sliding_window_min_max_mean
  import swmm_pkg::*;
#(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [LEN_W-1:0]       window_length_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [SAMPLE_BITS-1:0] window_max_o,
  output logic [SAMPLE_BITS-1:0] window_min_o,
  output logic [SAMPLE_BITS-1:0] window_mean_o,
  output logic [HELD_W-1:0]      samples_held_o
);

  swmm_cmd_t cmd;
  swmm_sts_t sts;

  swmm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  swmm_dpath #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_len_i (window_length_i),
    .sample_i  (sample_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .max_o     (window_max_o),
    .min_o     (window_min_o),
    .mean_o    (window_mean_o),
    .held_o    (samples_held_o)
  );

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for sliding_window_min_max_mean.
// Depends on swmm_pkg and the block's RTL. It predicts the window's max, min,
// mean and count for each sample beat and checks every result beat in order.
module tb;
  import swmm_pkg::*;

  localparam int SB          = SAMPLE_BITS_DEF;
  localparam int MAX_WIN     = MAX_WINDOW_DEF;
  localparam int SAMPLE_TOP  = (1 << SB) - 1;
  localparam int DRAIN_TAIL  = 40;
  localparam int RX_HOLD     = 300;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [SB-1:0]     wmax;
    logic [SB-1:0]     wmin;
    logic [SB-1:0]     wmean;
    logic [HELD_W-1:0] held;
  } window_stats_t;

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              cfg_we_i        = 1'b0;
  logic [LEN_W-1:0]  window_length_i = LEN_RESET;
  logic              in_valid_i      = 1'b0;
  logic              in_ready_o;
  logic [SB-1:0]     sample_i        = '0;
  logic              out_valid_o;
  logic              out_ready_i     = 1'b0;
  logic [SB-1:0]     window_max_o;
  logic [SB-1:0]     window_min_o;
  logic [SB-1:0]     window_mean_o;
  logic [HELD_W-1:0] samples_held_o;

  // shadow of the window state
  logic [SB-1:0]    ring_shadow [MAX_WIN];
  int unsigned      slot_shadow;
  int unsigned      count_shadow;
  int unsigned      sum_shadow;
  logic [LEN_W-1:0] length_shadow;

  window_stats_t stats_q [$];

  bit          in_idle_on  = 1'b1;
  bit          out_idle_on = 1'b1;
  int unsigned rx_hold_req = 0;
  int unsigned cycle_cnt   = 0;
  int unsigned err_cnt     = 0;
  int unsigned samples_sent   = 0;
  int unsigned results_seen   = 0;
  int unsigned length_writes  = 0;

  sliding_window_min_max_mean #(
    .MAX_WINDOW (MAX_WIN),
    .SAMPLE_BITS(SB)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .window_length_i(window_length_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_i       (sample_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .window_max_o   (window_max_o),
    .window_min_o   (window_min_o),
    .window_mean_o  (window_mean_o),
    .samples_held_o (samples_held_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic void clear_window();
    slot_shadow  = 0;
    count_shadow = 0;
    sum_shadow   = 0;
  endfunction

  function automatic window_stats_t predict_stats(input logic [SB-1:0] s);
    window_stats_t r;
    int unsigned   span;
    int unsigned   k;
    span = (length_shadow == 0) ? 1 : (length_shadow > MAX_WIN) ? MAX_WIN : length_shadow;
    if (slot_shadow >= span) slot_shadow = 0;
    if (count_shadow >= span) begin
      sum_shadow   = sum_shadow - ring_shadow[slot_shadow];
      count_shadow = span;
    end else begin
      count_shadow++;
    end
    ring_shadow[slot_shadow] = s;
    sum_shadow  = sum_shadow + s;
    slot_shadow = (slot_shadow + 1 >= span) ? 0 : slot_shadow + 1;
    r.wmax = ring_shadow[0];
    r.wmin = ring_shadow[0];
    for (k = 1; k < count_shadow; k++) begin
      if (ring_shadow[k] > r.wmax) r.wmax = ring_shadow[k];
      if (ring_shadow[k] < r.wmin) r.wmin = ring_shadow[k];
    end
    r.wmean = SB'(sum_shadow / count_shadow);
    r.held  = HELD_W'(count_shadow);
    return r;
  endfunction

  function automatic logic [SB-1:0] pick_sample(input logic [SB-1:0] prev);
    case ($urandom_range(9))
      0: return SB'($urandom_range(3));
      1: return SB'(SAMPLE_TOP - $urandom_range(3));
      2: return prev;
      default: return SB'($urandom_range(SAMPLE_TOP));
    endcase
  endfunction

  // Called at a rising edge; returns at the edge that accepted the beat.
  task automatic send_sample(input logic [SB-1:0] s);
    if (in_idle_on && $urandom_range(99) < 36) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 36);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    do @(posedge clk_i); while (!in_ready_o);
    stats_q.push_back(predict_stats(s));
    samples_sent++;
  endtask

  task automatic stop_input();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drain();
    while (stats_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_TAIL) @(posedge clk_i);
  endtask

  task automatic set_length(input logic [LEN_W-1:0] v);
    cfg_we_i        <= 1'b1;
    window_length_i <= v;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    length_shadow = v;
    clear_window();
    length_writes++;
  endtask

  // receiver side: random ready, with long hold-offs on request
  initial begin : rx_side
    int unsigned served;
    int unsigned n;
    served = 0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req != served) begin
        served++;
        out_ready_i <= 1'b0;
        for (n = 0; n < RX_HOLD; n++) @(posedge clk_i);
      end
      out_ready_i <= !(out_idle_on && $urandom_range(99) < 36);
    end
  end

  always @(posedge clk_i) begin
    window_stats_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (stats_q.size() == 0) begin
        $error("result beat with nothing expected: max %0d min %0d mean %0d held %0d",
               window_max_o, window_min_o, window_mean_o, samples_held_o);
        err_cnt++;
      end else begin
        want = stats_q.pop_front();
        if (window_max_o !== want.wmax) begin
          $error("window_max: expected %0d, got %0d", want.wmax, window_max_o);
          err_cnt++;
        end
        if (window_min_o !== want.wmin) begin
          $error("window_min: expected %0d, got %0d", want.wmin, window_min_o);
          err_cnt++;
        end
        if (window_mean_o !== want.wmean) begin
          $error("window_mean: expected %0d, got %0d", want.wmean, window_mean_o);
          err_cnt++;
        end
        if (samples_held_o !== want.held) begin
          $error("samples_held: expected %0d, got %0d", want.held, samples_held_o);
          err_cnt++;
        end
      end
    end
  end

  // default length after reset, field extremes and bit patterns
  task automatic test_reset_length();
    send_sample('0);
    send_sample(SB'(SAMPLE_TOP));
    send_sample(SB'(10'h2AA));
    send_sample(SB'(10'h155));
    send_sample(SB'(1));
    send_sample(SB'(SAMPLE_TOP - 1));
    stop_input();
    wait_drain();
  endtask

  // length 1, length 0 (acts as 1), length 2 wrap, rewrite of the same value
  task automatic test_short_windows();
    set_length(LEN_W'(1));
    send_sample(SB'(SAMPLE_TOP));
    send_sample('0);
    send_sample(SB'(5));
    stop_input();
    wait_drain();
    set_length('0);
    send_sample(SB'(7));
    send_sample(SB'(SAMPLE_TOP));
    send_sample(SB'(3));
    stop_input();
    wait_drain();
    set_length(LEN_W'(2));
    send_sample(SB'(SAMPLE_TOP));
    send_sample(SB'(SAMPLE_TOP - 2));
    send_sample('0);
    send_sample(SB'(9));
    stop_input();
    wait_drain();
    set_length(LEN_W'(2));
    send_sample(SB'(100));
    send_sample(SB'(1));
    send_sample(SB'(SAMPLE_TOP));
    stop_input();
    wait_drain();
  endtask

  task automatic run_phase(input logic [LEN_W-1:0] len, input int unsigned n);
    logic [SB-1:0] s;
    int unsigned   i;
    set_length(len);
    s = SB'($urandom_range(SAMPLE_TOP));
    for (i = 0; i < n; i++) begin
      s = pick_sample(s);
      send_sample(s);
    end
    stop_input();
    wait_drain();
  endtask

  task automatic test_random_windows();
    logic [LEN_W-1:0] lens [10];
    int unsigned      p;
    lens = '{LEN_W'(16), LEN_W'(1), '0, LEN_W'(31), LEN_W'(17), LEN_W'(2),
             LEN_W'(15), LEN_W'($urandom_range(31)), LEN_W'($urandom_range(31)),
             LEN_W'(16)};
    for (p = 0; p < 10; p++) begin
      // one long stretch without idling on either side
      in_idle_on  = (p != 6);
      out_idle_on <= (p != 6);
      run_phase(lens[p], (p == 6) ? 150 : $urandom_range(60, 120));
    end
    in_idle_on  = 1'b1;
    out_idle_on <= 1'b1;
  endtask

  // receiver holds off while the sender keeps offering beats
  task automatic test_backpressure();
    int unsigned i;
    set_length(LEN_W'($urandom_range(3, 16)));
    in_idle_on  = 1'b0;
    rx_hold_req <= rx_hold_req + 1;
    for (i = 0; i < 24; i++) send_sample(SB'($urandom_range(SAMPLE_TOP)));
    stop_input();
    wait_drain();
    in_idle_on = 1'b1;
  endtask

  initial begin
    for (int k = 0; k < MAX_WIN; k++) ring_shadow[k] = '0;
    length_shadow = LEN_RESET;
    clear_window();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_length();
    test_short_windows();
    test_random_windows();
    test_backpressure();
    wait_drain();
    $display("Run covered %0d samples and %0d result beats across %0d length writes,",
             samples_sent, results_seen, length_writes);
    $display("including lengths 0 and 31 and a %0d-cycle receiver stall.", RX_HOLD);
    if (err_cnt == 0 && stats_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/swmm_pkg.sv
rtl/core/swmm_ctrl.sv
rtl/core/swmm_dpath.sv
rtl/core/sliding_window_min_max_mean.sv
verif/tb.sv
